// File: rtl/plist_pkg.sv
`default_nettype none

package plist_pkg;

  // request codes carried in the input tuser
  localparam logic [1:0] REQ_DISPLAY = 2'd0;
  localparam logic [1:0] REQ_INSERT  = 2'd1;
  localparam logic [1:0] REQ_DELETE  = 2'd2;
  localparam logic [1:0] REQ_SEARCH  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // control from the sequencer to the entry store
  typedef struct packed {
    logic key_ld;   // capture the request word
    logic rd_en;    // read one entry into the read register
    logic wr_en;    // write one entry
    logic wr_key;   // write the request word instead of the read register
  } store_ctl_t;

endpackage

`default_nettype wire

// File: rtl/plist_store.sv
`default_nettype none

module plist_store
  import plist_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                  clk_i,
  input  wire store_ctl_t            ctl_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire logic signed [31:0]    key_i,
  output      logic [DATA_WIDTH-1:0] rdata_o,
  output      logic                  match_o
);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] key_q;

  // request word, sign-extended or cut to the entry width
  always_ff @(posedge clk_i) begin
    if (ctl_i.key_ld) begin
      key_q <= DATA_WIDTH'(key_i);
    end
  end

  // single write port: shifted entry from the read register or the new word
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= ctl_i.wr_key ? key_q : rdata_q;
    end
  end

  // single registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // shared comparator on the read register
  assign match_o = (rdata_q == key_q);
  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/positional_list_insert_delete_search_unit.sv
`default_nettype none

// Dense positional list of up to CAPACITY signed words with insert, delete,
// search and display, one request at a time. Requests enter on the s_axis
// port (tuser = request code) and results leave on m_axis, tlast marking the
// final result of each request; display gives one beat per entry (one beat on
// an empty list), all other requests one beat. The entries sit in a
// single-port-read, single-port-write memory with a registered read, so every
// entry moved, compared or shown is first read into the read register and
// then written, compared or emitted. A refused request goes straight to the
// output hand-off. The input is ready only between requests; the finished
// result waits in an output register, so the next request may be taken while
// the last result is still pending. The list resets to empty and needs no
// clearing pass.
module positional_list_insert_delete_search_unit
  import plist_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // position[4:0], value[36:5], zero pad
  input  wire logic [1:0]  s_axis_tuser_i,   // req_type[1:0]
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [47:0] m_axis_tdata_o,   // status[2:0], found_position[7:3],
                                             // element[39:8], count[44:40], zero pad
  output      logic        m_axis_tuser_o,   // element_valid
  output      logic        m_axis_tlast_o    // last
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > 5) ? CW : 5) + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP_RD  = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_WR   = 4'd3;
  localparam logic [3:0] S_INS_PUT  = 4'd4;
  localparam logic [3:0] S_DEL_RD   = 4'd5;
  localparam logic [3:0] S_DEL_WR   = 4'd6;
  localparam logic [3:0] S_SRCH_RD  = 4'd7;
  localparam logic [3:0] S_SRCH_CMP = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] tgt_q, tgt_d;
  logic [2:0]    stat_q, stat_d;
  logic [4:0]    fpos_q, fpos_d;
  logic          evld_q, evld_d;
  logic          last_q, last_d;

  logic        m_valid_q;
  logic [2:0]  m_status_q;
  logic [4:0]  m_fpos_q;
  logic [31:0] m_elem_q;
  logic        m_evld_q;
  logic [4:0]  m_count_q;
  logic        m_last_q;

  store_ctl_t            ctl;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  match;

  logic [1:0]         req_type;
  logic [4:0]         position;
  logic signed [31:0] value;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      cnt_ext;
  logic [CW-1:0]      idx_inc;
  logic               slot_free;
  logic               out_load;
  logic               in_fire;

  // input beat fields
  assign req_type = s_axis_tuser_i;
  assign position = s_axis_tdata_i[4:0];
  assign value    = $signed(s_axis_tdata_i[36:5]);

  assign pos_ext   = PW'(position);
  assign cnt_ext   = PW'(count_q);
  assign idx_inc   = CW'(idx_q) + CW'(1);
  assign slot_free = !m_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // entry memory and shared comparator
  plist_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .key_i     (value),
    .rdata_o   (rdata),
    .match_o   (match)
  );

  // request sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    tgt_d    = tgt_q;
    stat_d   = stat_q;
    fpos_d   = fpos_q;
    evld_d   = evld_q;
    last_d   = last_q;
    ctl      = '0;
    rd_addr  = idx_q;
    wr_addr  = idx_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          ctl.key_ld = 1'b1;
          stat_d     = ST_OK;
          fpos_d     = '0;
          evld_d     = 1'b0;
          last_d     = 1'b1;
          state_d    = S_EMIT;
          case (req_type)
            REQ_DISPLAY: begin
              if (count_q != '0) begin
                idx_d   = '0;
                state_d = S_DISP_RD;
              end
            end
            REQ_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                stat_d = ST_FULL;
              end else if (pos_ext == '0 || pos_ext > cnt_ext + PW'(1)) begin
                stat_d = ST_BADPOS;
              end else begin
                idx_d = AW'(count_q);
                tgt_d = AW'(pos_ext - PW'(1));
                if (pos_ext == cnt_ext + PW'(1)) begin
                  state_d = S_INS_PUT;
                end else begin
                  state_d = S_INS_RD;
                end
              end
            end
            REQ_DELETE: begin
              if (count_q == '0) begin
                stat_d = ST_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                stat_d = ST_BADPOS;
              end else begin
                idx_d = AW'(pos_ext - PW'(1));
                if (pos_ext == cnt_ext) begin
                  count_d = count_q - CW'(1);
                end else begin
                  state_d = S_DEL_RD;
                end
              end
            end
            default: begin
              if (count_q == '0) begin
                stat_d = ST_NOTFOUND;
              end else begin
                idx_d   = '0;
                state_d = S_SRCH_RD;
              end
            end
          endcase
        end
      end
      // display: fetch one entry, then hand it to the output
      S_DISP_RD: begin
        ctl.rd_en = 1'b1;
        evld_d    = 1'b1;
        last_d    = (idx_inc == count_q);
        state_d   = S_EMIT;
      end
      // insert: move entries up one slot, top first
      S_INS_RD: begin
        ctl.rd_en = 1'b1;
        rd_addr   = idx_q - AW'(1);
        state_d   = S_INS_WR;
      end
      S_INS_WR: begin
        ctl.wr_en = 1'b1;
        idx_d     = idx_q - AW'(1);
        if (idx_q - AW'(1) == tgt_q) begin
          state_d = S_INS_PUT;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_INS_PUT: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_key = 1'b1;
        count_d    = count_q + CW'(1);
        state_d    = S_EMIT;
      end
      // delete: move entries down one slot, bottom first
      S_DEL_RD: begin
        ctl.rd_en = 1'b1;
        rd_addr   = idx_q + AW'(1);
        state_d   = S_DEL_WR;
      end
      S_DEL_WR: begin
        ctl.wr_en = 1'b1;
        idx_d     = idx_q + AW'(1);
        if (idx_inc == count_q - CW'(1)) begin
          count_d = count_q - CW'(1);
          state_d = S_EMIT;
        end else begin
          state_d = S_DEL_RD;
        end
      end
      // search: read, then compare against the request word
      S_SRCH_RD: begin
        ctl.rd_en = 1'b1;
        state_d   = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (match) begin
          fpos_d  = 5'(idx_inc);
          state_d = S_EMIT;
        end else if (idx_inc == count_q) begin
          stat_d  = ST_NOTFOUND;
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_SRCH_RD;
        end
      end
      // hand the result to the output register once it has room
      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (evld_q && !last_q) begin
            idx_d   = idx_q + AW'(1);
            state_d = S_DISP_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // per-request working registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    tgt_q  <= tgt_d;
    stat_q <= stat_d;
    fpos_q <= fpos_d;
    evld_q <= evld_d;
    last_q <= last_d;
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_status_q <= stat_q;
      m_fpos_q   <= fpos_q;
      m_elem_q   <= evld_q ? 32'($signed(rdata)) : '0;
      m_evld_q   <= evld_q;
      m_count_q  <= 5'(count_q);
      m_last_q   <= last_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, m_count_q, m_elem_q, m_fpos_q, m_status_q};
  assign m_axis_tuser_o  = m_evld_q;
  assign m_axis_tlast_o  = m_last_q;

  // the list never grows past its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // the count moves by at most one per request step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |->
      (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)))
    else $error("entry count jumped");

  // an accepted request keeps the input closed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("input open right after accepting a request");

  // a result is loaded only into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready_i))
    else $error("result overwrote a pending beat");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import plist_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned DATA_WIDTH   = 32;
  localparam int unsigned STALL_PCT    = 8;
  localparam int unsigned DRAIN_CYCLES = 60;

  // one result beat as the block should present it
  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         found_pos;
    logic signed [31:0] element;
    logic               elem_valid;
    logic [4:0]         count;
    logic               last;
  } list_beat_t;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = REQ_DISPLAY;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // shadow copy of the list and the beats still owed by the block
  logic signed [31:0] list_words [CAPACITY];
  int                 list_len = 0;
  list_beat_t         expected_beats [$];
  int unsigned        mismatch_cnt = 0;
  bit                 no_gaps = 1'b0;

  positional_list_insert_delete_search_unit #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // queue one expected beat, count taken after the request
  function automatic void push_beat(logic [2:0] status, logic [4:0] fpos,
                                    logic signed [31:0] elem, logic ev, logic last);
    list_beat_t b;
    b.status     = status;
    b.found_pos  = fpos;
    b.element    = elem;
    b.elem_valid = ev;
    b.count      = 5'(list_len);
    b.last       = last;
    expected_beats.push_back(b);
  endfunction

  // apply one accepted request to the shadow list
  function automatic void predict_request(logic [1:0] kind, logic [4:0] pos,
                                          logic signed [31:0] val);
    int p;
    int hit;
    p   = int'(pos);
    hit = 0;
    case (kind)
      REQ_DISPLAY: begin
        if (list_len == 0) begin
          push_beat(ST_OK, 5'd0, 32'sd0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            push_beat(ST_OK, 5'd0, list_words[i], 1'b1, logic'(i == list_len - 1));
        end
      end
      REQ_INSERT: begin
        if (list_len >= CAPACITY) begin
          push_beat(ST_FULL, 5'd0, 32'sd0, 1'b0, 1'b1);
        end else if (p < 1 || p > list_len + 1) begin
          push_beat(ST_BADPOS, 5'd0, 32'sd0, 1'b0, 1'b1);
        end else begin
          for (int i = list_len; i >= p; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = val;
          list_len++;
          push_beat(ST_OK, 5'd0, 32'sd0, 1'b0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (list_len == 0) begin
          push_beat(ST_EMPTY, 5'd0, 32'sd0, 1'b0, 1'b1);
        end else if (p < 1 || p > list_len) begin
          push_beat(ST_BADPOS, 5'd0, 32'sd0, 1'b0, 1'b1);
        end else begin
          for (int i = p - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          push_beat(ST_OK, 5'd0, 32'sd0, 1'b0, 1'b1);
        end
      end
      REQ_SEARCH: begin
        for (int i = 0; i < list_len && hit == 0; i++)
          if (list_words[i] == val) hit = i + 1;
        if (hit != 0) push_beat(ST_OK, 5'(hit), 32'sd0, 1'b0, 1'b1);
        else          push_beat(ST_NOTFOUND, 5'd0, 32'sd0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // words: partly a small pool so duplicates and search hits are common, plus the two extremes and random words
  function automatic logic signed [31:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return 32'($signed($urandom_range(7)) - 4);
    if (roll < 42) return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  // drive one request beat and wait for its handshake
  task automatic send_request(input logic [1:0] kind, input logic [4:0] pos,
                              input logic signed [31:0] val);
    while (!no_gaps && $urandom_range(99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, val, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(kind, pos, val);
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // result side: random back-pressure and beat checking
  always @(posedge clk) begin
    list_beat_t want;
    m_tready <= no_gaps || ($urandom_range(99) >= STALL_PCT);
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: tdata 0x%0h", m_tdata);
        mismatch_cnt++;
      end else begin
        want = expected_beats.pop_front();
        compare_field("status", 32'(want.status), 32'(m_tdata[2:0]));
        compare_field("found_position", 32'(want.found_pos), 32'(m_tdata[7:3]));
        compare_field("element", want.element, m_tdata[39:8]);
        compare_field("element_valid", 32'(want.elem_valid), 32'(m_tuser));
        compare_field("count", 32'(want.count), 32'(m_tdata[44:40]));
        compare_field("last", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  // every request kind on an empty list
  task automatic test_empty_list();
    send_request(REQ_DISPLAY, 5'd0, 32'sd0);
    send_request(REQ_DELETE, 5'd1, 32'sd0);
    send_request(REQ_SEARCH, 5'd0, 32'sd0);
    send_request(REQ_INSERT, 5'd0, 32'sd5);
    send_request(REQ_INSERT, 5'd2, 32'sd5);
  endtask

  // front, middle and end inserts up to capacity, then refused inserts and a display
  task automatic test_fill_to_capacity();
    send_request(REQ_INSERT, 5'd1, 32'sh7FFF_FFFF);
    send_request(REQ_INSERT, 5'd2, 32'sh8000_0000);
    send_request(REQ_INSERT, 5'd1, -32'sd1);
    send_request(REQ_INSERT, 5'd2, 32'sd0);
    while (list_len < CAPACITY)
      send_request(REQ_INSERT, 5'($urandom_range(list_len + 1, 1)), pick_word());
    send_request(REQ_INSERT, 5'd31, 32'sd7);
    send_request(REQ_INSERT, 5'd1, 32'sd7);
    send_request(REQ_DISPLAY, 5'd0, 32'sd0);
  endtask

  // hit on the most negative word, the last entry, and a search that should miss
  task automatic test_search_hits();
    send_request(REQ_SEARCH, 5'd0, 32'sh8000_0000);
    send_request(REQ_SEARCH, 5'd31, list_words[list_len-1]);
    send_request(REQ_SEARCH, 5'd0, 32'sh0BAD_F00D);
  endtask

  // out-of-range deletes first, then first, last and middle entries, then a display
  task automatic test_delete_positions();
    send_request(REQ_DELETE, 5'd0, 32'sd0);
    send_request(REQ_DELETE, 5'(list_len + 1), 32'sd0);
    send_request(REQ_DELETE, 5'd31, 32'sd0);
    send_request(REQ_DELETE, 5'd1, 32'sd0);
    send_request(REQ_DELETE, 5'(list_len), 32'sd0);
    send_request(REQ_DELETE, 5'(list_len / 2), 32'sd0);
    send_request(REQ_DISPLAY, 5'd0, 32'sd0);
  endtask

  // list swings between full and empty; mostly legal positions
  task automatic test_random_mix(input int unsigned n_items);
    logic [1:0]         kind;
    logic [4:0]         pos;
    logic signed [31:0] val;
    bit                 growing;
    int unsigned        roll;
    growing = 1'b1;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (list_len == CAPACITY) growing = 1'b0;
      if (list_len == 0)        growing = 1'b1;
      roll = $urandom_range(99);
      if (roll < 8)       kind = REQ_DISPLAY;
      else if (roll < 25) kind = REQ_SEARCH;
      else if (roll < 80) kind = growing ? REQ_INSERT : REQ_DELETE;
      else                kind = growing ? REQ_DELETE : REQ_INSERT;
      if ($urandom_range(9) == 0) pos = 5'($urandom);
      else if (kind == REQ_INSERT) pos = 5'($urandom_range(list_len + 1, 1));
      else if (list_len > 0) pos = 5'($urandom_range(list_len, 1));
      else pos = 5'd1;
      if (kind == REQ_SEARCH && list_len > 0 && $urandom_range(1) == 1)
        val = list_words[$urandom_range(list_len - 1)];
      else
        val = pick_word();
      send_request(kind, pos, val);
    end
  endtask

  // same mix with both sides streaming without gaps
  task automatic test_back_to_back(input int unsigned n_items);
    no_gaps = 1'b1;
    test_random_mix(n_items);
    no_gaps = 1'b0;
  endtask

  // sequence and final verdict
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_to_capacity();
    test_search_hits();
    test_delete_positions();
    test_random_mix(40);
    test_back_to_back(30);
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: positional_list_insert_delete_search_unit.f
rtl/plist_pkg.sv
rtl/plist_store.sv
rtl/positional_list_insert_delete_search_unit.sv
dv/tb_top.sv
